[hdl/sldd_pkg.sv]
// Shared types and constants for the slew-limited differential drive.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package sldd_pkg;

    // Field and register widths
    localparam int STEP_W     = 14;
    localparam int FS_W       = 10;
    localparam int LIM_W      = 11;
    localparam int DRIVE_W    = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    // Register reset values
    localparam logic [STEP_W-1:0] RST_FWD_RAMP_STEP  = 14'd40;
    localparam logic [STEP_W-1:0] RST_TURN_RAMP_STEP = 14'd40;
    localparam logic [STEP_W-1:0] RST_DECAY_STEP     = 14'd40;
    localparam logic [FS_W-1:0]   RST_FULL_SCALE     = 10'd1000;
    localparam logic [LIM_W-1:0]  RST_OUTPUT_LIMIT   = 11'd500;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FWD_RAMP_STEP  = 3'd0,
        CFG_TURN_RAMP_STEP = 3'd1,
        CFG_DECAY_STEP     = 3'd2,
        CFG_FULL_SCALE     = 3'd3,
        CFG_OUTPUT_LIMIT   = 3'd4
    } t_cfg_idx;

    // Target direction of one axis
    typedef enum logic [1:0] {
        DIR_ZERO = 2'd0,
        DIR_POS  = 2'd1,
        DIR_NEG  = 2'd2
    } t_dir;

    // Per-tick command to one axis
    typedef struct packed {
        logic en;
        t_dir dir;
    } t_axis_cmd;

endpackage

`default_nettype wire

[hdl/sldd_if.sv]
// Handshake interfaces for key requests, drive results and register writes.
// Depends on sldd_pkg for the payload widths.
`default_nettype none

interface sldd_key_if import sldd_pkg::*; ();
    logic valid;
    logic ready;
    logic key_forward;
    logic key_back;
    logic key_left;
    logic key_right;

    modport source (output valid, key_forward, key_back, key_left, key_right,
                    input ready);
    modport sink   (input valid, key_forward, key_back, key_left, key_right,
                    output ready);
endinterface

interface sldd_drive_if import sldd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;

    modport source (output valid, left_drive, right_drive, input ready);
    modport sink   (input valid, left_drive, right_drive, output ready);
endinterface

interface sldd_cfg_if import sldd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/sldd_axis.sv]
// One axis of the drive: level register slewed toward a +/-full-scale or zero target.
// Depends on sldd_pkg for the command struct and widths.
`default_nettype none

module sldd_axis import sldd_pkg::*; #(
    parameter int FRAC_BITS = 4
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire t_axis_cmd                        i_cmd,
    input  wire logic [STEP_W-1:0]                i_ramp_step,
    input  wire logic [STEP_W-1:0]                i_decay_step,
    input  wire logic [FS_W-1:0]                  i_full_scale,
    output      logic signed [FRAC_BITS+11:0]     o_level
);

    localparam int LVL_W = FRAC_BITS + 12;
    localparam int CW    = LVL_W + 2;

    logic signed [LVL_W-1:0] r_level;
    logic signed [LVL_W-1:0] n_level;
    logic signed [CW-1:0]    fs_ext;
    logic signed [CW-1:0]    target;
    logic signed [CW-1:0]    step;
    logic signed [CW-1:0]    level_ext;
    logic signed [CW-1:0]    diff;
    logic signed [CW-1:0]    slewed;

    // Form target and step, then move by at most one step
    always_comb begin
        fs_ext    = signed'({{(CW-FS_W-FRAC_BITS){1'b0}}, i_full_scale,
                             {FRAC_BITS{1'b0}}});
        level_ext = signed'({{(CW-LVL_W){r_level[LVL_W-1]}}, r_level});
        case (i_cmd.dir)
            DIR_POS: begin
                target = fs_ext;
            end
            DIR_NEG: begin
                target = -fs_ext;
            end
            default: begin
                target = '0;
            end
        endcase
        // Ramp toward a nonzero target; decay toward zero, even with both keys of a pair held
        if (target != '0) begin
            step = signed'({{(CW-STEP_W){1'b0}}, i_ramp_step});
        end else begin
            step = signed'({{(CW-STEP_W){1'b0}}, i_decay_step});
        end
        diff = target - level_ext;
        if (diff > step) begin
            slewed = level_ext + step;
        end else if (diff < -step) begin
            slewed = level_ext - step;
        end else begin
            slewed = target;
        end
        n_level = slewed[LVL_W-1:0];
    end

    // Advance the level once per accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_cmd.en) begin
            r_level <= n_level;
        end
    end

    assign o_level = r_level;

endmodule

`default_nettype wire

[hdl/sldd_clip.sv]
// Clip a mixed level to +/-limit and truncate it toward zero to whole units.
// Depends on sldd_pkg for the limit and drive widths.
`default_nettype none

module sldd_clip import sldd_pkg::*; #(
    parameter int FRAC_BITS = 4
) (
    input  wire logic signed [FRAC_BITS+12:0] i_mix,
    input  wire logic [LIM_W-1:0]             i_limit,
    output      logic signed [DRIVE_W-1:0]    o_drive
);

    localparam int CW = FRAC_BITS + 13;

    logic signed [CW-1:0] lim;
    logic signed [CW-1:0] clipped;
    logic signed [CW-1:0] mag;
    logic signed [CW-1:0] whole;
    logic signed [CW-1:0] res;

    always_comb begin
        lim = signed'({{(CW-LIM_W-FRAC_BITS){1'b0}}, i_limit, {FRAC_BITS{1'b0}}});
        // Clip to the symmetric bound
        if (i_mix > lim) begin
            clipped = lim;
        end else if (i_mix < -lim) begin
            clipped = -lim;
        end else begin
            clipped = i_mix;
        end
        // Truncate magnitude, then restore sign
        mag   = clipped[CW-1] ? -clipped : clipped;
        whole = mag >>> FRAC_BITS;
        res   = clipped[CW-1] ? -whole : whole;
        o_drive = res[DRIVE_W-1:0];
    end

endmodule

`default_nettype wire

[hdl/slew_limited_differential_drive.sv]
// Top level of the slew-limited differential drive mixer.
// Depends on sldd_pkg, sldd_if, sldd_axis and sldd_clip.
//
//  Port      | Dir | Carries
//  ----------+-----+------------------------------------------------
//  i_key     | in  | four key flags, one request per control tick
//  o_drive   | out | left_drive / right_drive, one result per request
//  i_cfg     | in  | register index and write data, always ready
//
// A request updates both axis levels at its accepting edge; the clipped mix is
// registered into the output register as the mix stage advances. One request
// per cycle unless the output stalls; stalls hold the mix stage, then i_key.ready.
// Reset (synchronous, active low) zeros both levels and loads register defaults.
`default_nettype none

module slew_limited_differential_drive import sldd_pkg::*; #(
    parameter int FRAC_BITS = 4
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    sldd_key_if.sink     i_key,
    sldd_drive_if.source o_drive,
    sldd_cfg_if.sink     i_cfg
);

    localparam int LVL_W = FRAC_BITS + 12;

    logic [STEP_W-1:0] r_fwd_ramp_step;
    logic [STEP_W-1:0] r_turn_ramp_step;
    logic [STEP_W-1:0] r_decay_step;
    logic [FS_W-1:0]   r_full_scale;
    logic [LIM_W-1:0]  r_output_limit;

    logic                      r_mix_valid;
    logic                      r_out_valid;
    logic signed [DRIVE_W-1:0] r_left;
    logic signed [DRIVE_W-1:0] r_right;

    logic                      accept;
    logic                      mix_advance;
    t_axis_cmd                 fwd_cmd;
    t_axis_cmd                 turn_cmd;
    logic signed [LVL_W-1:0]   fwd_level;
    logic signed [LVL_W-1:0]   turn_level;
    logic signed [LVL_W:0]     mix_left;
    logic signed [LVL_W:0]     mix_right;
    logic signed [DRIVE_W-1:0] n_left;
    logic signed [DRIVE_W-1:0] n_right;

    // Register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_ramp_step  <= RST_FWD_RAMP_STEP;
            r_turn_ramp_step <= RST_TURN_RAMP_STEP;
            r_decay_step     <= RST_DECAY_STEP;
            r_full_scale     <= RST_FULL_SCALE;
            r_output_limit   <= RST_OUTPUT_LIMIT;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_FWD_RAMP_STEP:  r_fwd_ramp_step  <= i_cfg.data[STEP_W-1:0];
                CFG_TURN_RAMP_STEP: r_turn_ramp_step <= i_cfg.data[STEP_W-1:0];
                CFG_DECAY_STEP:     r_decay_step     <= i_cfg.data[STEP_W-1:0];
                CFG_FULL_SCALE:     r_full_scale     <= i_cfg.data[FS_W-1:0];
                CFG_OUTPUT_LIMIT:   r_output_limit   <= i_cfg.data[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Handshake: mix stage drains when the output register is free or taken
    assign mix_advance = r_mix_valid && (!r_out_valid || o_drive.ready);
    assign i_key.ready = !r_mix_valid || mix_advance;
    assign accept      = i_key.valid && i_key.ready;

    // Decode key pairs into axis directions
    always_comb begin
        fwd_cmd.en  = accept;
        turn_cmd.en = accept;
        case ({i_key.key_forward, i_key.key_back})
            2'b10:   fwd_cmd.dir = DIR_POS;
            2'b01:   fwd_cmd.dir = DIR_NEG;
            default: fwd_cmd.dir = DIR_ZERO;
        endcase
        case ({i_key.key_right, i_key.key_left})
            2'b10:   turn_cmd.dir = DIR_POS;
            2'b01:   turn_cmd.dir = DIR_NEG;
            default: turn_cmd.dir = DIR_ZERO;
        endcase
    end

    sldd_axis #(.FRAC_BITS(FRAC_BITS)) u_fwd (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (fwd_cmd),
        .i_ramp_step  (r_fwd_ramp_step),
        .i_decay_step (r_decay_step),
        .i_full_scale (r_full_scale),
        .o_level      (fwd_level)
    );

    sldd_axis #(.FRAC_BITS(FRAC_BITS)) u_turn (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (turn_cmd),
        .i_ramp_step  (r_turn_ramp_step),
        .i_decay_step (r_decay_step),
        .i_full_scale (r_full_scale),
        .o_level      (turn_level)
    );

    // Mix the two axes
    assign mix_left  = {fwd_level[LVL_W-1], fwd_level} + {turn_level[LVL_W-1], turn_level};
    assign mix_right = {fwd_level[LVL_W-1], fwd_level} - {turn_level[LVL_W-1], turn_level};

    sldd_clip #(.FRAC_BITS(FRAC_BITS)) u_clip_left (
        .i_mix   (mix_left),
        .i_limit (r_output_limit),
        .o_drive (n_left)
    );

    sldd_clip #(.FRAC_BITS(FRAC_BITS)) u_clip_right (
        .i_mix   (mix_right),
        .i_limit (r_output_limit),
        .o_drive (n_right)
    );

    // Pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mix_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_mix_valid <= 1'b1;
            end else if (mix_advance) begin
                r_mix_valid <= 1'b0;
            end
            if (mix_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_drive.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (mix_advance) begin
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    assign o_drive.valid       = r_out_valid;
    assign o_drive.left_drive  = r_left;
    assign o_drive.right_drive = r_right;

endmodule

`default_nettype wire
